>>> design/esd_pkg.sv
// ============================================================================
// esd_pkg
// Shared types, constants and calendar tables for the epoch-to-date converter.
// ============================================================================
package esd_pkg;

   localparam int unsigned SecsW  = 32;
   localparam int unsigned RemW   = 17;
   localparam int unsigned DaysW  = 16;
   localparam int unsigned MinsW  = 11;
   localparam int unsigned YearW  = 12;
   localparam int unsigned MonthW = 4;
   localparam int unsigned DayW   = 5;
   localparam int unsigned HourW  = 5;
   localparam int unsigned MinW   = 6;

   // Whole days: the seconds over 128 (25 bits) times a rounded-up reciprocal
   // of 675, shifted down by 35, is exact over the full 25-bit range.
   localparam int unsigned DayQW         = 25;
   localparam int unsigned DayRecipW     = 26;
   localparam int unsigned DayProdW      = DayQW + DayRecipW;
   localparam int unsigned DayRecipShift = 35;
   localparam logic [DayRecipW-1:0] DayRecip = 26'd50903317;

   // Division by 60 for values below 2^17: rounded-up reciprocal, shift by 23.
   localparam int unsigned SixtyRecipW     = 18;
   localparam int unsigned SixtyProdW      = RemW + SixtyRecipW;
   localparam int unsigned SixtyRecipShift = 23;
   localparam logic [SixtyRecipW-1:0] SixtyRecip = 18'd139811;

   localparam logic [RemW-1:0]   DivisorDay     = 17'd86400;
   localparam logic [MinW-1:0]   MinsPerHour    = 6'd60;
   localparam logic [YearW-1:0]  FirstYear      = 12'd1970;
   localparam logic [YearW-1:0]  CenturyNoLeap  = 12'd2100;
   localparam logic [YearW-1:0]  LastFullQuad   = 12'd2098;
   localparam logic [DaysW-1:0]  DaysCommonYear = 16'd365;
   localparam logic [DaysW-1:0]  DaysLeapYear   = 16'd366;
   localparam logic [DaysW-1:0]  DaysQuad       = 16'd1461;
   localparam logic [MonthW-1:0] LastMonth      = 4'd11;

   typedef struct packed {
      logic load_input;
      logic calc_days;
      logic calc_in_day;
      logic calc_mins;
      logic calc_hour;
      logic save_time;
      logic year_step;
      logic month_step;
      logic publish;
   } esd_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } esd_sts_type;

   // Reachable years run from 1970 to 2106. Inside that span the only year
   // divisible by 4 that is not a leap year is 2100 (2000 is divisible by 400).
   function automatic logic is_leap(input logic [YearW-1:0] y);
      return (y[1:0] == 2'b00) && (y != CenturyNoLeap);
   endfunction

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
      logic [DayW-1:0] len;
      case (m)
         4'd1:                len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8,
         4'd10:               len = 5'd30;
         default:             len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> design/esd_ctrl.sv
// ============================================================================
// esd_ctrl
// Sequencer for the converter: reciprocal steps, year walk, month walk and
// result hand-off.
// ============================================================================
module esd_ctrl
   import esd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  esd_sts_type sts,
   output esd_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DAYS   = 4'd1;
   localparam logic [3:0] ST_IN_DAY = 4'd2;
   localparam logic [3:0] ST_MINS   = 4'd3;
   localparam logic [3:0] ST_HOUR   = 4'd4;
   localparam logic [3:0] ST_SAVE   = 4'd5;
   localparam logic [3:0] ST_YEAR   = 4'd6;
   localparam logic [3:0] ST_MONTH  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = ST_DAYS;
            end
         end
         ST_DAYS: begin
            cmd.calc_days = 1'b1;
            state_in      = ST_IN_DAY;
         end
         ST_IN_DAY: begin
            cmd.calc_in_day = 1'b1;
            state_in        = ST_MINS;
         end
         ST_MINS: begin
            cmd.calc_mins = 1'b1;
            state_in      = ST_HOUR;
         end
         ST_HOUR: begin
            cmd.calc_hour = 1'b1;
            state_in      = ST_SAVE;
         end
         ST_SAVE: begin
            cmd.save_time = 1'b1;
            state_in      = ST_YEAR;
         end
         ST_YEAR: begin
            if (sts.year_done) state_in = ST_MONTH;
            else cmd.year_step = 1'b1;
         end
         ST_MONTH: begin
            if (sts.month_done) state_in = ST_DONE;
            else cmd.month_step = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/esd_dp.sv
// ============================================================================
// esd_dp
// Datapath: reciprocal multipliers, year and month walkers, result word.
// ============================================================================
module esd_dp
   import esd_pkg::*;
(
   input  logic              clock,
   input  esd_cmd_type       cmd,
   input  logic [SecsW-1:0]  req_epoch_seconds,
   output esd_sts_type       sts,
   output logic [YearW-1:0]  rsp_year,
   output logic [MonthW-1:0] rsp_month_index,
   output logic [DayW-1:0]   rsp_day_of_month,
   output logic [HourW-1:0]  rsp_hour,
   output logic [MinW-1:0]   rsp_minute
);

   logic [SecsW-1:0]  secs_ff, secs_in;
   logic [RemW-1:0]   in_day_ff, in_day_in;
   logic [MinsW-1:0]  mins_ff, mins_in;
   logic [DaysW-1:0]  days_ff, days_in;
   logic [YearW-1:0]  year_ff, year_in;
   logic [MonthW-1:0] month_ff, month_in;
   logic [HourW-1:0]  hour_ff, hour_in;
   logic [MinW-1:0]   minute_ff, minute_in;

   logic [YearW-1:0]  out_year_ff;
   logic [MonthW-1:0] out_month_ff;
   logic [DayW-1:0]   out_day_ff;
   logic [HourW-1:0]  out_hour_ff;
   logic [MinW-1:0]   out_minute_ff;

   logic [DayProdW-1:0]   day_prod;
   logic [RemW-1:0]       day_base;
   logic [RemW-1:0]       sixty_arg;
   logic [SixtyProdW-1:0] sixty_prod;
   logic [MinW-1:0]       hour_mins;
   logic                  leap;
   logic [DaysW-1:0]      ylen;
   logic [DaysW-1:0]      mlen;
   logic                  quad_ok;

   // Whole days are the seconds over 128 divided by 675, done as a multiply
   // by the scaled reciprocal.
   assign day_prod = {{DayRecipW{1'b0}}, secs_ff[SecsW-1:SecsW-DayQW]}
                     * {{DayQW{1'b0}}, DayRecip};

   // The seconds of the day are below 2^17, so the low 17 bits of the whole
   // days times 86400 are all that the subtraction needs.
   assign day_base = {1'b0, days_ff} * DivisorDay;

   // One multiplier by 1/60 serves both the minutes of the day and the hour.
   assign sixty_arg  = cmd.calc_hour ? {{(RemW-MinsW){1'b0}}, mins_ff} : in_day_ff;
   assign sixty_prod = {{SixtyRecipW{1'b0}}, sixty_arg} * {{RemW{1'b0}}, SixtyRecip};

   // The minute is below 60, so the low six bits of the difference suffice.
   assign hour_mins = {1'b0, hour_ff} * MinsPerHour;

   // A block of four years starting at a year that is 2 mod 4 holds exactly
   // one leap day, except the block that contains 2100.
   assign leap    = is_leap(year_ff);
   assign ylen    = leap ? DaysLeapYear : DaysCommonYear;
   assign quad_ok = (year_ff[1:0] == 2'b10) && (year_ff != LastFullQuad)
                    && (days_ff >= DaysQuad);
   assign mlen    = {{(DaysW-DayW){1'b0}}, month_len(month_ff, leap)};

   assign sts.year_done  = !quad_ok && (days_ff < ylen);
   assign sts.month_done = (month_ff == LastMonth) || (days_ff < mlen);

   always_comb begin
      secs_in   = secs_ff;
      in_day_in = in_day_ff;
      mins_in   = mins_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      if (cmd.load_input) begin
         secs_in = req_epoch_seconds;
      end
      if (cmd.calc_days) begin
         days_in = day_prod[DayRecipShift +: DaysW];
      end
      if (cmd.calc_in_day) begin
         in_day_in = secs_ff[RemW-1:0] - day_base;
      end
      if (cmd.calc_mins) begin
         mins_in = sixty_prod[SixtyRecipShift +: MinsW];
      end
      if (cmd.calc_hour) begin
         hour_in = sixty_prod[SixtyRecipShift +: HourW];
      end
      if (cmd.save_time) begin
         minute_in = mins_ff[MinW-1:0] - hour_mins;
         year_in   = FirstYear;
         month_in  = '0;
      end
      if (cmd.year_step) begin
         if (quad_ok) begin
            days_in = days_ff - DaysQuad;
            year_in = year_ff + 12'd4;
         end else begin
            days_in = days_ff - ylen;
            year_in = year_ff + 12'd1;
         end
      end
      if (cmd.month_step) begin
         days_in  = days_ff - mlen;
         month_in = month_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      in_day_ff <= in_day_in;
      mins_ff   <= mins_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      if (cmd.publish) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= month_ff;
         out_day_ff    <= days_ff[DayW-1:0] + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
      end
   end

   assign rsp_year         = out_year_ff;
   assign rsp_month_index  = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_minute_ff;

endmodule

>>> design/epoch_seconds_to_date.sv
// An accepted word first has its seconds split by reciprocal multiplies,
// then runs the year walk, one four-year block or single year per step, and
// the month walk; a finished result may then wait for the previous result
// word to be taken. A new word is taken only once the current one has been
// handed to the output register. Reset (synchronous, active high) empties
// the block.
// ============================================================================
// epoch_seconds_to_date
// Converts whole seconds since 1970-01-01 UTC into year, month, day, hour
// and minute.
// ============================================================================
module epoch_seconds_to_date
   import esd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SecsW-1:0]  req_epoch_seconds,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [YearW-1:0]  rsp_year,
   output logic [MonthW-1:0] rsp_month_index,
   output logic [DayW-1:0]   rsp_day_of_month,
   output logic [HourW-1:0]  rsp_hour,
   output logic [MinW-1:0]   rsp_minute
);

   // The controller sequences the work; the datapath holds every value.
   // Whole days come from multiplying the seconds over 128 by a reciprocal
   // of 675, and the seconds of the day from taking the whole days back out.
   // Two more multiplies by a reciprocal of 60 give the minutes of the day
   // and then the hour, and the minute is what is left over. The seconds
   // within the minute are dropped.
   esd_cmd_type cmd;
   esd_sts_type sts;

   esd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The result word sits in its own output register, so the next input
   // word can be worked on while the previous result waits to be taken.
   esd_dp u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .req_epoch_seconds (req_epoch_seconds),
      .sts               (sts),
      .rsp_year          (rsp_year),
      .rsp_month_index   (rsp_month_index),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute)
   );

endmodule

>>> design/esd_checker.sv
// ============================================================================
// esd_checker
// Port-level checks for the epoch-to-date converter, bound to the top level.
// ============================================================================
module esd_checker
   import esd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [YearW-1:0]  rsp_year,
   input logic [MonthW-1:0] rsp_month_index,
   input logic [DayW-1:0]   rsp_day_of_month,
   input logic [HourW-1:0]  rsp_hour,
   input logic [MinW-1:0]   rsp_minute
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in work");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##1 !$rose(rsp_valid))
      else $error("result appeared right after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year)
         && $stable(rsp_month_index) && $stable(rsp_day_of_month)
         && $stable(rsp_hour) && $stable(rsp_minute))
      else $error("stalled result word changed");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_year >= 12'd1970 && rsp_year <= 12'd2106
         && rsp_month_index <= 4'd11 && rsp_day_of_month >= 5'd1
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59)
      else $error("result field out of range");

endmodule

bind epoch_seconds_to_date esd_checker u_esd_checker (.*);
